// ===== src/ffba_pkg.sv =====
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int FIELD_W = 16;
    localparam int STATUS_W = 3;
    localparam logic [FIELD_W-1:0] HEAP_RESET = 16'd10000;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_ZERO_SIZE  = 3'd1,
        ST_NO_SPACE   = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_NOT_FOUND  = 3'd4
    } t_status;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] request_size;
        logic [FIELD_W-1:0] block_address;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] granted_address;
    } t_rsp;

    // Table port strobes.
    typedef struct packed {
        logic we;
        logic re;
    } t_tbl_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EV,
        S_END,
        S_TAIL,
        S_UP_RD,
        S_UP_WR,
        S_INS,
        S_FEV,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } t_state;

endpackage

// ===== src/first_fit_block_allocator_core.sv =====
`timescale 1ns / 1ps

// First-fit block allocator over a heap of heap_length units from address 0.
// Request: drive i_req and raise start; the transfer happens at a clock edge
// where start is high and busy is low. kind 0 allocates request_size units,
// kind 1 frees the block whose base equals block_address.
// Result: o_done is high for exactly one cycle with o_rsp (status and, for a
// successful allocate, the granted base). The receiver cannot stall it.
// Config: i_cfg_we writes i_cfg_wdata into heap_length; write only while idle.
// Allocate scans the blocks in order (S_EV, S_END per block) and then checks
// the trailing gap (S_TAIL); on a fit it shifts the later blocks up (S_UP_RD,
// S_UP_WR) and writes the new entry (S_INS). Free scans for the matching base
// (S_FEV) and shifts the later blocks down (S_DN_RD, S_DN_WR). The pace is set by
// the table's one read and one write port and the one shared adder/compare unit.
// busy is high from the transfer through the o_done cycle; one item at a time.
// Reset empties the table (count to zero) and sets heap_length to 10000;
// no clearing pass is needed.
module first_fit_block_allocator_core #(
    parameter int MAX_BLOCKS = 64,
    parameter int ADDR_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ffba_pkg::t_req                      i_req,
    output logic                                o_done,
    output ffba_pkg::t_rsp                      o_rsp,
    input  logic                                i_cfg_we,
    input  logic [ffba_pkg::FIELD_W-1:0]        i_cfg_wdata
);

    localparam int FW   = ffba_pkg::FIELD_W;
    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);
    localparam int CW   = ((ADDR_BITS > FW) ? ADDR_BITS : FW) + 2;
    localparam int DW   = 2 * ADDR_BITS;
    localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_BLOCKS);
    localparam logic [CNTW-1:0] ONE  = CNTW'(1);
    localparam logic [CNTW-1:0] TWO  = CNTW'(2);

    ffba_pkg::t_state  r_state, n_state;
    logic [CNTW-1:0]   r_count;
    logic [CNTW-1:0]   r_idx;
    logic [CNTW-1:0]   r_sidx;
    logic [FW-1:0]     r_heap;
    logic [FW-1:0]     r_size;
    logic [FW-1:0]     r_addr;
    logic [CW-1:0]     r_prev_end;
    ffba_pkg::t_status r_status;
    logic [FW-1:0]     r_grant;

    ffba_pkg::t_tbl_cmd tbl_cmd;
    logic [IW-1:0]      tbl_waddr;
    logic [IW-1:0]      tbl_raddr;
    logic [DW-1:0]      tbl_wdata;
    logic [DW-1:0]      tbl_rdata;

    logic [CW-1:0] u_a, u_b, u_c, u_sum;
    logic          u_fits, u_match;

    logic [CW-1:0]   base_ext, len_ext, size_ext, addr_ext, heap_ext;
    logic [CNTW-1:0] idx_inc, sidx_inc, sidx_dec;
    logic            accept;

    assign base_ext = CW'(tbl_rdata[DW-1:ADDR_BITS]);
    assign len_ext  = CW'(tbl_rdata[ADDR_BITS-1:0]);
    assign size_ext = CW'(r_size);
    assign addr_ext = CW'(r_addr);
    assign heap_ext = CW'(r_heap);
    assign idx_inc  = r_idx + ONE;
    assign sidx_inc = r_sidx + ONE;
    assign sidx_dec = r_sidx - ONE;
    assign accept   = start && (r_state == ffba_pkg::S_IDLE);

    ffba_table #(
        .DEPTH (MAX_BLOCKS),
        .DW    (DW)
    ) u_table (
        .i_clk   (i_clk),
        .i_cmd   (tbl_cmd),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    ffba_cmp #(
        .W (CW)
    ) u_cmp (
        .i_a     (u_a),
        .i_b     (u_b),
        .i_c     (u_c),
        .o_sum   (u_sum),
        .o_fits  (u_fits),
        .o_match (u_match)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffba_pkg::S_IDLE: begin
                if (start) begin
                    if (i_req.kind == ffba_pkg::KIND_ALLOC) begin
                        if (i_req.request_size == '0 || r_count == MAXC) begin
                            n_state = ffba_pkg::S_DONE;
                        end else if (r_count == '0) begin
                            n_state = ffba_pkg::S_TAIL;
                        end else begin
                            n_state = ffba_pkg::S_EV;
                        end
                    end else begin
                        n_state = (r_count == '0) ? ffba_pkg::S_DONE : ffba_pkg::S_FEV;
                    end
                end
            end
            ffba_pkg::S_EV:    n_state = u_fits ? ffba_pkg::S_UP_RD : ffba_pkg::S_END;
            ffba_pkg::S_END:   n_state = (idx_inc == r_count) ? ffba_pkg::S_TAIL : ffba_pkg::S_EV;
            ffba_pkg::S_TAIL:  n_state = u_fits ? ffba_pkg::S_INS : ffba_pkg::S_DONE;
            ffba_pkg::S_UP_RD: n_state = ffba_pkg::S_UP_WR;
            ffba_pkg::S_UP_WR: n_state = (sidx_dec == r_idx) ? ffba_pkg::S_INS : ffba_pkg::S_UP_RD;
            ffba_pkg::S_INS:   n_state = ffba_pkg::S_DONE;
            ffba_pkg::S_FEV: begin
                if (idx_inc == r_count) begin
                    n_state = ffba_pkg::S_DONE;
                end else if (u_match) begin
                    n_state = ffba_pkg::S_DN_RD;
                end
            end
            ffba_pkg::S_DN_RD: n_state = ffba_pkg::S_DN_WR;
            ffba_pkg::S_DN_WR: begin
                n_state = ((r_sidx + TWO) == r_count) ? ffba_pkg::S_DONE : ffba_pkg::S_DN_RD;
            end
            ffba_pkg::S_DONE:  n_state = ffba_pkg::S_IDLE;
            default:           n_state = ffba_pkg::S_IDLE;
        endcase
    end

    // Table port and shared unit operands.
    always_comb begin
        tbl_cmd   = '0;
        tbl_waddr = '0;
        tbl_raddr = '0;
        tbl_wdata = '0;
        u_a       = '0;
        u_b       = '0;
        u_c       = '0;
        case (r_state)
            ffba_pkg::S_IDLE: begin
                // Keep entry 0 on the read port for the first compare.
                tbl_cmd.re = 1'b1;
            end
            ffba_pkg::S_EV: begin
                u_a = r_prev_end;
                u_b = size_ext;
                u_c = base_ext;
            end
            ffba_pkg::S_END: begin
                u_a        = base_ext;
                u_b        = len_ext;
                tbl_cmd.re = 1'b1;
                tbl_raddr  = idx_inc[IW-1:0];
            end
            ffba_pkg::S_TAIL: begin
                u_a = r_prev_end;
                u_b = size_ext;
                u_c = heap_ext;
            end
            ffba_pkg::S_UP_RD: begin
                tbl_cmd.re = 1'b1;
                tbl_raddr  = sidx_dec[IW-1:0];
            end
            ffba_pkg::S_UP_WR: begin
                tbl_cmd.we = 1'b1;
                tbl_waddr  = r_sidx[IW-1:0];
                tbl_wdata  = tbl_rdata;
            end
            ffba_pkg::S_INS: begin
                tbl_cmd.we = 1'b1;
                tbl_waddr  = r_idx[IW-1:0];
                tbl_wdata  = {r_prev_end[ADDR_BITS-1:0], size_ext[ADDR_BITS-1:0]};
            end
            ffba_pkg::S_FEV: begin
                u_a        = base_ext;
                u_c        = addr_ext;
                tbl_cmd.re = !u_match && (idx_inc != r_count);
                tbl_raddr  = idx_inc[IW-1:0];
            end
            ffba_pkg::S_DN_RD: begin
                tbl_cmd.re = 1'b1;
                tbl_raddr  = sidx_inc[IW-1:0];
            end
            ffba_pkg::S_DN_WR: begin
                tbl_cmd.we = 1'b1;
                tbl_waddr  = r_sidx[IW-1:0];
                tbl_wdata  = tbl_rdata;
            end
            default: begin
                tbl_cmd = '0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::S_IDLE;
            r_count <= '0;
            r_heap  <= ffba_pkg::HEAP_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_heap <= i_cfg_wdata;
            end
            if (r_state == ffba_pkg::S_INS) begin
                r_count <= r_count + ONE;
            end else if ((r_state == ffba_pkg::S_FEV && u_match)
                         && idx_inc == r_count) begin
                r_count <= r_count - ONE;
            end else if (r_state == ffba_pkg::S_DN_WR && (r_sidx + TWO) == r_count) begin
                r_count <= r_count - ONE;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ffba_pkg::S_IDLE: begin
                r_size     <= i_req.request_size;
                r_addr     <= i_req.block_address;
                r_idx      <= '0;
                r_prev_end <= '0;
                r_grant    <= '0;
                if (i_req.kind == ffba_pkg::KIND_ALLOC) begin
                    if (i_req.request_size == '0) begin
                        r_status <= ffba_pkg::ST_ZERO_SIZE;
                    end else if (r_count == MAXC) begin
                        r_status <= ffba_pkg::ST_TABLE_FULL;
                    end else begin
                        r_status <= ffba_pkg::ST_NO_SPACE;
                    end
                end else begin
                    r_status <= ffba_pkg::ST_NOT_FOUND;
                end
            end
            ffba_pkg::S_EV: begin
                r_sidx <= r_count;
            end
            ffba_pkg::S_END: begin
                r_prev_end <= u_sum;
                r_idx      <= idx_inc;
            end
            ffba_pkg::S_TAIL: begin
                r_idx <= r_count;
            end
            ffba_pkg::S_UP_WR: begin
                r_sidx <= sidx_dec;
            end
            ffba_pkg::S_INS: begin
                r_status <= ffba_pkg::ST_OK;
                r_grant  <= r_prev_end[FW-1:0];
            end
            ffba_pkg::S_FEV: begin
                r_sidx <= r_idx;
                if (u_match) begin
                    r_status <= ffba_pkg::ST_OK;
                end else begin
                    r_idx <= idx_inc;
                end
            end
            ffba_pkg::S_DN_WR: begin
                r_sidx <= sidx_inc;
            end
            default: begin
                r_sidx <= r_sidx;
            end
        endcase
    end

    assign busy                  = (r_state != ffba_pkg::S_IDLE);
    assign o_done                = (r_state == ffba_pkg::S_DONE);
    assign o_rsp.status          = r_status;
    assign o_rsp.granted_address = r_grant;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAXC)
        else $error("block count above table depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after request transfer");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy held after result");

    a_count_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> o_done)
        else $error("block count changed outside a result");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffba_pkg::S_IDLE) |-> !tbl_cmd.we)
        else $error("table written while idle");

endmodule

// ===== src/ffba_cmp.sv =====
`timescale 1ns / 1ps

// Shared adder with compare: sum = a + b, fits = (a + b <= c), match = (a + b == c).
module ffba_cmp #(
    parameter int W = 18
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_c,
    output logic [W-1:0] o_sum,
    output logic         o_fits,
    output logic         o_match
);

    assign o_sum   = i_a + i_b;
    assign o_fits  = (o_sum <= i_c);
    assign o_match = (o_sum == i_c);

endmodule

// ===== src/ffba_table.sv =====
`timescale 1ns / 1ps

// Block table: one write port, one read port with registered read data.
module ffba_table #(
    parameter int DEPTH = 64,
    parameter int DW    = 32
) (
    input  logic                     i_clk,
    input  ffba_pkg::t_tbl_cmd       i_cmd,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/tb_first_fit_block_allocator_core.sv =====
`timescale 1ns / 1ps

module tb_first_fit_block_allocator_core;
    import ffba_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int LATENCY_CYCLES = 2 * TABLE_DEPTH + 8;
    localparam int CYCLE_LIMIT    = 1000000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_req                 i_req;
    logic                 o_done;
    t_rsp                 o_rsp;
    logic                 i_cfg_we;
    logic [FIELD_W-1:0]   i_cfg_wdata;

    // Shadow of the allocator: ordered block table and heap size.
    logic [FIELD_W-1:0]   model_base[$];
    logic [FIELD_W-1:0]   model_len[$];
    logic [FIELD_W-1:0]   model_heap_len;

    t_rsp                 awaited_rsp[$];
    int                   status_tally[5];
    int                   n_issued    = 0;
    int                   n_results   = 0;
    int                   err_cnt     = 0;
    int                   peak_fill   = 0;
    int                   cycle_cnt   = 0;
    bit                   gaps_on     = 1'b1;

    first_fit_block_allocator_core #(
        .MAX_BLOCKS (TABLE_DEPTH),
        .ADDR_BITS  (FIELD_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d responses outstanding",
                 cycle_cnt, awaited_rsp.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Work out the response of one request and update the shadow table.
    function automatic t_rsp first_fit_outcome(input t_req r);
        t_rsp        rsp;
        int unsigned run_end;
        int          pos;
        int          hit;
        rsp.status          = ST_OK;
        rsp.granted_address = '0;
        run_end             = 0;
        pos                 = -1;
        hit                 = -1;
        if (r.kind == KIND_ALLOC) begin
            if (r.request_size == '0) begin
                rsp.status = ST_ZERO_SIZE;
            end else if (model_base.size() >= TABLE_DEPTH) begin
                rsp.status = ST_TABLE_FULL;
            end else begin
                if (model_base.size() == 0) begin
                    if (r.request_size <= model_heap_len)
                        pos = 0;
                end else if (model_base[0] != '0 && r.request_size <= model_base[0]) begin
                    pos = 0;
                end else begin
                    for (int i = 0; i + 1 < model_base.size() && pos < 0; i++) begin
                        run_end = model_base[i] + model_len[i];
                        if (run_end + r.request_size <= model_base[i+1])
                            pos = i + 1;
                    end
                    // Trailing gap is the only one bounded by the heap size.
                    if (pos < 0) begin
                        run_end = model_base[model_base.size()-1]
                                + model_len[model_len.size()-1];
                        if (run_end + r.request_size <= model_heap_len)
                            pos = model_base.size();
                    end
                end
                if (pos < 0) begin
                    rsp.status = ST_NO_SPACE;
                end else begin
                    model_base.insert(pos, FIELD_W'(run_end));
                    model_len.insert(pos, r.request_size);
                    rsp.granted_address = FIELD_W'(run_end);
                end
            end
        end else begin
            foreach (model_base[i])
                if (hit < 0 && model_base[i] == r.block_address)
                    hit = i;
            if (hit < 0) begin
                rsp.status = ST_NOT_FOUND;
            end else begin
                model_base.delete(hit);
                model_len.delete(hit);
            end
        end
        return rsp;
    endfunction

    function automatic t_req alloc_req(input logic [FIELD_W-1:0] size);
        t_req r;
        r.kind          = KIND_ALLOC;
        r.request_size  = size;
        r.block_address = FIELD_W'($urandom);
        return r;
    endfunction

    function automatic t_req free_req(input logic [FIELD_W-1:0] base);
        t_req r;
        r.kind          = KIND_FREE;
        r.request_size  = FIELD_W'($urandom);
        r.block_address = base;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input t_rsp want, input t_rsp got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t: %s: expected status %0d addr %0d, got status %0d addr %0d",
                     $realtime, what, want.status, want.granted_address,
                     got.status, got.granted_address);
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done === 1'b1) begin
            n_results++;
            if (awaited_rsp.size() == 0) begin
                want = '0;
                note_mismatch("response with nothing outstanding", want, o_rsp);
            end else begin
                want = awaited_rsp.pop_front();
                if (o_rsp.status !== want.status
                        || o_rsp.granted_address !== want.granted_address)
                    note_mismatch("response mismatch", want, o_rsp);
            end
        end
    end

    // Hold the request until the transfer; start stays high for the next call unless a random gap drops it.
    task automatic issue_req(input t_req r);
        t_rsp rsp;
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        rsp = first_fit_outcome(r);
        awaited_rsp.push_back(rsp);
        status_tally[rsp.status]++;
        n_issued++;
        if (model_base.size() > peak_fill)
            peak_fill = model_base.size();
        if (gaps_on && $urandom_range(0, 99) < 25) begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 140)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_heap_len(input logic [FIELD_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        model_heap_len = value;
        i_cfg_we    <= 1'b0;
    endtask

    task automatic free_all();
        while (model_base.size() != 0)
            issue_req(free_req(model_base[0]));
    endtask

    task automatic test_empty_table_cases();
        issue_req(free_req(16'd0));
        issue_req(alloc_req(16'd0));
        issue_req(alloc_req(16'hFFFF));
        issue_req(alloc_req(16'd10001));
        issue_req(alloc_req(16'd10000));
        issue_req(alloc_req(16'd1));
        issue_req(free_req(16'd0));
        issue_req(free_req(16'd0));
    endtask

    task automatic test_gap_order();
        issue_req(alloc_req(16'd100));
        issue_req(alloc_req(16'd200));
        issue_req(alloc_req(16'd300));
        issue_req(free_req(16'd100));
        // Too big for the hole between blocks, lands after the last one.
        issue_req(alloc_req(16'd250));
        issue_req(alloc_req(16'd200));
        issue_req(free_req(16'd0));
        issue_req(alloc_req(16'd50));
        issue_req(free_req(16'd17));
        free_all();
    endtask

    task automatic test_heap_bounds();
        wait_idle();
        write_heap_len(16'd0);
        issue_req(alloc_req(16'd1));
        wait_idle();
        write_heap_len(16'd1);
        issue_req(alloc_req(16'd1));
        issue_req(alloc_req(16'd1));
        issue_req(free_req(16'd0));
        wait_idle();
        write_heap_len(16'd1000);
        issue_req(alloc_req(16'd400));
        issue_req(alloc_req(16'd400));
        // Shrink below the existing blocks: only the trailing gap is limited.
        wait_idle();
        write_heap_len(16'd500);
        issue_req(free_req(16'd0));
        issue_req(alloc_req(16'd300));
        issue_req(alloc_req(16'd50));
        issue_req(alloc_req(16'd200));
        free_all();
    endtask

    task automatic run_phase(input logic [FIELD_W-1:0] heap, input int items,
                             input int alloc_pct, input int size_cap, input bit with_gaps);
        t_req r;
        int   roll;
        wait_idle();
        write_heap_len(heap);
        gaps_on = with_gaps;
        repeat (items) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                r = {1'($urandom), FIELD_W'($urandom), FIELD_W'($urandom)};
            end else if (roll < alloc_pct) begin
                case ($urandom_range(0, 19))
                    0:       r = alloc_req('0);
                    1:       r = alloc_req(FIELD_W'($urandom));
                    2:       r = alloc_req(model_heap_len);
                    default: r = alloc_req(FIELD_W'($urandom_range(1, size_cap)));
                endcase
            end else if (model_base.size() != 0 && $urandom_range(0, 9) != 0) begin
                r = free_req(model_base[$urandom_range(0, model_base.size() - 1)]);
            end else begin
                r = free_req(FIELD_W'($urandom));
            end
            issue_req(r);
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        // Blocks carry over between phases, so heap changes also land on live tables.
        run_phase(16'hFFFF, 120, 85, 256, 1'b1);
        run_phase(16'hFFFF, 110, 50, 2048, 1'b0);
        run_phase(16'd3000, 110, 45, 128, 1'b1);
        run_phase(16'd1, 90, 30, 4, 1'b1);
        run_phase(FIELD_W'($urandom_range(1, 65535)), 110, 55, 512, 1'b1);
        run_phase(16'd10000, 110, 60, 64, 1'b1);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        model_heap_len = HEAP_RESET;
        foreach (status_tally[i])
            status_tally[i] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table_cases();
        test_gap_order();
        test_heap_bounds();
        test_random_traffic();

        wait_idle();
        repeat (LATENCY_CYCLES) @(posedge i_clk);

        $display("Requests %0d, responses %0d, peak table fill %0d of %0d, mismatches %0d",
                 n_issued, n_results, peak_fill, TABLE_DEPTH, err_cnt);
        $display("Status mix: ok %0d, zero size %0d, no space %0d, table full %0d, not found %0d",
                 status_tally[ST_OK], status_tally[ST_ZERO_SIZE], status_tally[ST_NO_SPACE],
                 status_tally[ST_TABLE_FULL], status_tally[ST_NOT_FOUND]);
        if (err_cnt == 0 && awaited_rsp.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ffba_pkg.sv
src/ffba_cmp.sv
src/ffba_table.sv
src/first_fit_block_allocator_core.sv
verif/tb_first_fit_block_allocator_core.sv
